FILE: src/f2b4_pkg.sv
// Package for the binary32 to base-4 16-bit code encoder.
// Holds field widths, code constants and shared types; no dependencies.
`default_nettype none

package f2b4_pkg;

    localparam int unsigned FLOAT_W = 32;
    localparam int unsigned CODE_W  = 16;
    localparam int unsigned MAG_W   = 15;
    localparam int unsigned EXP_W   = 7;
    localparam int unsigned MANT_W  = 8;
    localparam int unsigned SIG_W   = 24;

    typedef logic [FLOAT_W-1:0] float_t;
    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [MAG_W-1:0]   mag_t;

    // Magnitude codes for the special cases
    localparam mag_t MAG_NAN   = 15'h7FFF;
    localparam mag_t MAG_INF   = 15'h7F00;
    localparam mag_t MAG_ZERO  = 15'h0000;
    // Smallest exponent-1 code: exponent 1, mantissa 64
    localparam mag_t MAG_PROMO = 15'h0140;

    localparam logic [7:0] BEXP_ALL_ONES = 8'hFF;
    localparam logic [7:0] BEXP_SMALL_MAX = 8'd2;
    localparam logic [7:0] EXP_TOP = 8'd127;

endpackage

`default_nettype wire

FILE: src/f2b4_encode.sv
// Combinational core: binary32 bit pattern to 16-bit ordered base-4 code.
// Depends on f2b4_pkg.
`default_nettype none

module f2b4_encode (
    input  wire  f2b4_pkg::float_t float_bits,
    output f2b4_pkg::code_t        code
);
    import f2b4_pkg::*;

    logic             neg;
    logic [7:0]       bexp;
    logic [22:0]      frac;
    logic [SIG_W-1:0] sig;
    logic [SIG_W:0]   sum16, sum17, sum18, sum19;
    logic [8:0]       m_norm;
    logic [6:0]       m_small;
    logic [7:0]       e_base;
    logic [7:0]       e_norm;
    logic [MANT_W-1:0] m_final;
    mag_t             mag;

    // Field split; hidden bit present for every nonzero biased exponent
    assign neg  = float_bits[31];
    assign bexp = float_bits[30:23];
    assign frac = float_bits[22:0];
    assign sig  = {(bexp != 8'd0), frac};

    // Round-half-up at the four fixed shift amounts
    assign sum16 = {1'b0, sig} + (25'd1 << 15);
    assign sum17 = {1'b0, sig} + (25'd1 << 16);
    assign sum18 = {1'b0, sig} + (25'd1 << 17);
    assign sum19 = {1'b0, sig} + (25'd1 << 18);

    // Normal range: odd biased exponent means even binary exponent
    assign m_norm  = bexp[0] ? {1'b0, sum17[24:17]} : sum16[24:16];
    // Small range: biased exponent 2 shifts by 18, 0 and 1 by 19
    assign m_small = (bexp == BEXP_SMALL_MAX) ? sum18[24:18] : {1'b0, sum19[24:19]};

    // Base-4 exponent is floor((bexp - 1) / 2), with carry on mantissa overflow
    assign e_base  = (bexp - 8'd1) >> 1;
    assign e_norm  = m_norm[8] ? (e_base + 8'd1) : e_base;
    assign m_final = m_norm[8] ? 8'd64 : m_norm[7:0];

    // Magnitude select
    always_comb
    begin
        if (bexp == BEXP_ALL_ONES)
        begin
            mag = (frac != 23'd0) ? MAG_NAN : MAG_INF;
        end
        else if (bexp == 8'd0 && frac == 23'd0)
        begin
            mag = MAG_ZERO;
        end
        else if (bexp <= BEXP_SMALL_MAX)
        begin
            mag = m_small[6] ? MAG_PROMO : {8'd0, m_small};
        end
        else if (e_norm >= EXP_TOP)
        begin
            mag = MAG_INF;
        end
        else
        begin
            mag = {e_norm[EXP_W-1:0], m_final};
        end
    end

    // Negative values: complement the magnitude for ordering
    assign code = {neg, neg ? ~mag : mag};

endmodule

`default_nettype wire

FILE: src/float32_to_base4_float16_encoder.sv
// Each transaction passes through two registers in order: the input register, then the result register.
// Throughput: one transaction per cycle, sustained under continuous ready.
// The encode logic sits between the input register and the result register.
// Reset (rst_n, asynchronous, active low) clears both valid flags; payloads are not reset.
// Top level; depends on f2b4_pkg and f2b4_encode.
`default_nettype none

module float32_to_base4_float16_encoder (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire  f2b4_pkg::float_t float_bits,
    output logic                   out_valid,
    input  wire                    out_ready,
    output f2b4_pkg::code_t        code
);
    import f2b4_pkg::*;

    logic   in_vld_reg;
    logic   in_vld_next;
    float_t in_data_reg;
    logic   out_vld_reg;
    logic   out_vld_next;
    code_t  out_data_reg;
    code_t  enc_code;
    logic   out_load;
    logic   in_load;

    // Pipeline handshake: each stage loads when empty or draining
    assign out_load = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || out_load;
    assign in_load  = in_valid && in_ready;

    assign in_vld_next  = in_load || (in_vld_reg && !out_load);
    assign out_vld_next = out_load || (out_vld_reg && !out_ready);

    // Encode core
    f2b4_encode u_encode (
        .float_bits (in_data_reg),
        .code       (enc_code)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= float_bits;
        end
        if (out_load)
        begin
            out_data_reg <= enc_code;
        end
    end

    assign out_valid = out_vld_reg;
    assign code      = out_data_reg;

endmodule

`default_nettype wire
